[hdl/rarc_pkg.sv]
// Package with the shared widths and types of the rational add, reduce and compare unit.
`timescale 1ns / 1ps
package rarc_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH;
    localparam int CNT_WIDTH   = $clog2(WIDE_WIDTH);
    localparam int NUM_W       = 32;
    localparam int DEN_W       = 31;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-2:0]        b;
        logic signed [VALUE_WIDTH-1:0] c;
        logic [VALUE_WIDTH-2:0]        d;
        logic                          zerr;
        logic                          eq;
    } t_item;

    typedef struct packed {
        logic signed [NUM_W-1:0] sum_num;
        logic [DEN_W-1:0]        sum_den;
        logic                    less_than;
        logic                    equal;
        logic                    zero_den_error;
        logic                    overflow;
    } t_result;
endpackage

[hdl/rarc_front.sv]
// Front end: accepts requests, extracts and classifies operands, and queues them.
`timescale 1ns / 1ps
module rarc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rarc_pkg::IN_TDATA_W-1:0]   i_data,
    output logic                              o_item_valid,
    input  logic                              i_item_pop,
    output rarc_pkg::t_item                   o_item
);
    rarc_pkg::t_item r_q [2];
    logic [1:0]      r_cnt;
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      n_cnt;
    rarc_pkg::t_item w_new;
    logic            w_push;

    always_comb begin
        w_new.a    = i_data[rarc_pkg::VALUE_WIDTH-1:0];
        w_new.b    = i_data[32 +: rarc_pkg::VALUE_WIDTH-1];
        w_new.c    = i_data[63 +: rarc_pkg::VALUE_WIDTH];
        w_new.d    = i_data[95 +: rarc_pkg::VALUE_WIDTH-1];
        w_new.zerr = (w_new.b == '0) || (w_new.d == '0);
        w_new.eq   = (w_new.a == w_new.c) && (w_new.b == w_new.d);
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !(i_item_pop && o_item_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_item_pop && o_item_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_item_pop && o_item_valid) begin
                r_rd <= ~r_rd;
            end
        end
        if (w_push) begin
            r_q[r_wr] <= w_new;
        end
    end
endmodule

[hdl/rarc_back.sv]
// Back end: cross products, binary gcd, serial division and the result register.
`timescale 1ns / 1ps
module rarc_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    output logic                     o_item_pop,
    input  rarc_pkg::t_item          i_item,
    output logic                     o_valid,
    input  logic                     i_ready,
    output rarc_pkg::t_result        o_result
);
    localparam int VW = rarc_pkg::VALUE_WIDTH;
    localparam int W2 = rarc_pkg::WIDE_WIDTH;
    localparam int CW = rarc_pkg::CNT_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_GCD, S_DIVN, S_DIVD, S_FIN, S_OUT
    } t_state;

    t_state                r_state;
    rarc_pkg::t_item       r_item;
    logic signed [W2-1:0]  r_ad;
    logic signed [W2-1:0]  r_cb;
    logic [W2-1:0]         r_dd;
    logic [W2-1:0]         r_mag;
    logic                  r_neg;
    logic                  r_lt;
    logic [W2-1:0]         r_u;
    logic [W2-1:0]         r_v;
    logic [CW:0]           r_k;
    logic [W2-1:0]         r_g;
    logic [W2-1:0]         r_q;
    logic [W2:0]           r_rem;
    logic [CW-1:0]         r_cnt;
    logic [W2-1:0]         r_qn;
    rarc_pkg::t_result     r_res;

    logic signed [W2-1:0]  w_n;
    logic [W2:0]           w_rsh;
    logic                  w_ge;
    logic [W2-1:0]         w_lim;
    logic                  w_ovf;
    logic [VW-1:0]         w_num;

    assign w_n   = r_ad + r_cb;
    assign w_rsh = {r_rem[W2-1:0], r_q[W2-1]};
    assign w_ge  = (w_rsh >= {1'b0, r_g});
    assign w_lim = W2'(1) << (VW - 1);
    assign w_ovf = (r_neg ? (r_qn > w_lim) : (r_qn > w_lim - W2'(1)))
                   || (r_q > w_lim - W2'(1));
    assign w_num = r_neg ? VW'(W2'(0) - r_qn) : r_qn[VW-1:0];

    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign o_valid    = (r_state == S_OUT);
    assign o_result   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item  <= i_item;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_ad    <= r_item.a * $signed({1'b0, r_item.d});
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_cb    <= r_item.c * $signed({1'b0, r_item.b});
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_dd    <= W2'(r_item.b) * W2'(r_item.d);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_lt  <= (r_ad < r_cb);
                    r_neg <= w_n[W2-1];
                    r_mag <= w_n[W2-1] ? W2'(-w_n) : W2'(w_n);
                    r_u   <= w_n[W2-1] ? W2'(-w_n) : W2'(w_n);
                    r_v   <= r_dd;
                    r_k   <= '0;
                    if (r_item.zerr) begin
                        r_res.sum_num        <= '0;
                        r_res.sum_den        <= rarc_pkg::DEN_W'(1);
                        r_res.less_than      <= (r_ad < r_cb);
                        r_res.equal          <= r_item.eq;
                        r_res.zero_den_error <= 1'b1;
                        r_res.overflow       <= 1'b0;
                        r_state              <= S_OUT;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_u == '0 || r_v == '0) begin
                        r_g     <= (r_u | r_v) << r_k;
                        r_q     <= r_mag;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVN;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + (CW+1)'(1);
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u >= r_v) begin
                        r_u <= r_u - r_v;
                    end else begin
                        r_v <= r_v - r_u;
                    end
                end
                S_DIVN, S_DIVD: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(W2 - 1) && r_state == S_DIVN) begin
                        r_qn    <= {r_q[W2-2:0], w_ge};
                        r_q     <= r_dd;
                        r_rem   <= '0;
                        r_state <= S_DIVD;
                    end else begin
                        r_rem <= w_ge ? (w_rsh - {1'b0, r_g}) : w_rsh;
                        r_q   <= {r_q[W2-2:0], w_ge};
                        if (r_cnt == CW'(W2 - 1)) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_res.less_than      <= r_lt;
                    r_res.equal          <= r_item.eq;
                    r_res.zero_den_error <= 1'b0;
                    r_res.overflow       <= w_ovf;
                    r_res.sum_num        <= w_ovf ? '0 : rarc_pkg::NUM_W'($signed(w_num));
                    r_res.sum_den        <= w_ovf ? rarc_pkg::DEN_W'(1)
                                                  : rarc_pkg::DEN_W'(r_q[VW-2:0]);
                    r_state              <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[hdl/rational_add_reduce_compare_unit.sv]
// Top level of the rational add, reduce and compare unit.
//
//   Channel  Direction  Handshake                Contents
//   s_axis   in         s_axis_tvalid/tready     lhs_num, lhs_den, rhs_num, rhs_den
//   m_axis   out        m_axis_tvalid/tready     sum, flags
//
// A request with a zero denominator goes from the products and the add straight to its
// result. Any other request passes the products and the add, the binary gcd over 64-bit
// values, a serial restoring division of the numerator and then of the denominator by the
// gcd, and a final step that checks for overflow and writes the result.
// Reset is synchronous and active low; the two-entry queue lets the input side
// take requests while the back end works or its result waits.
`timescale 1ns / 1ps
module rational_add_reduce_compare_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // lhs_num[31:0], lhs_den[62:32], rhs_num[94:63], rhs_den[125:95], zero pad
    input  logic [rarc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sum_num[31:0], sum_den[62:32], less_than[63], equal[64],
    // zero_den_error[65], overflow[66], zero pad
    output logic [rarc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    logic              w_item_valid;
    logic              w_item_pop;
    rarc_pkg::t_item   w_item;
    rarc_pkg::t_result w_res;

    rarc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop),
        .o_item       (w_item)
    );

    rarc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .i_item       (w_item),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.overflow, w_res.zero_den_error, w_res.equal,
                           w_res.less_than, w_res.sum_den, w_res.sum_num};
endmodule

[hdl/rarc_checker.sv]
// Port checker for the rational unit and its bind to the top level.
`timescale 1ns / 1ps
module rarc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rarc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");
    a_zerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[65] |->
        m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[62:32] == 31'd1 && !m_axis_tdata[66])
        else $error("Zero denominator result is not 0/1.");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[66] |->
        m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[62:32] == 31'd1)
        else $error("Overflow result is not 0/1.");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[62:32] != 31'd0)
        else $error("Zero denominator in result.");
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[63] && m_axis_tdata[64]))
        else $error("Less-than and equal both set.");
endmodule

bind rational_add_reduce_compare_unit rarc_checker u_rarc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/rational_add_reduce_compare_unit_checker.sv]
// Checker that predicts and compares the results of the rational add, reduce and compare unit.
`timescale 1ns / 1ps
module rational_add_reduce_compare_unit_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [rarc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [rarc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    rarc_pkg::t_result sums_due[$];

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = y;
            y = x % y;
            x = t;
        end
        return x;
    endfunction

    function automatic rarc_pkg::t_result rational_sum(
        logic [rarc_pkg::IN_TDATA_W-1:0] req);
        rarc_pkg::t_result r;
        longint a, c, ad, cb, n;
        longint unsigned b, d, dd, mag, g, lim;
        logic neg;
        a = longint'(signed'(req[31:0]));
        b = longint'(req[62:32]);
        c = longint'(signed'(req[94:63]));
        d = longint'(req[125:95]);
        ad = a * longint'(d);
        cb = c * longint'(b);
        r.sum_num = '0;
        r.sum_den = 31'd1;
        r.less_than = ad < cb;
        r.equal = (a == c) && (b == d);
        r.zero_den_error = (b == 0) || (d == 0);
        r.overflow = 1'b0;
        if (!r.zero_den_error) begin
            n = ad + cb;
            dd = b * d;
            neg = n < 0;
            mag = neg ? longint'(-n) : n;
            g = euclid_gcd(mag, dd);
            lim = 64'd1 << 31;
            mag = mag / g;
            dd = dd / g;
            if ((neg ? (mag > lim) : (mag > lim - 1)) || dd > lim - 1) begin
                r.overflow = 1'b1;
            end else begin
                r.sum_num = neg ? 32'(-mag) : 32'(mag);
                r.sum_den = 31'(dd);
            end
        end
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        rarc_pkg::t_result want;
        rarc_pkg::t_result got;
        int errs;
        errs = 0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sums_due.push_back(rational_sum(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.sum_num = m_axis_tdata[31:0];
                got.sum_den = m_axis_tdata[62:32];
                got.less_than = m_axis_tdata[63];
                got.equal = m_axis_tdata[64];
                got.zero_den_error = m_axis_tdata[65];
                got.overflow = m_axis_tdata[66];
                if (sums_due.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    errs++;
                end else begin
                    want = sums_due.pop_front();
                    if (want.sum_num !== got.sum_num) begin
                        $error("sum_num expected %0d actual %0d", want.sum_num, got.sum_num);
                        errs++;
                    end
                    if (want.sum_den !== got.sum_den) begin
                        $error("sum_den expected %0d actual %0d", want.sum_den, got.sum_den);
                        errs++;
                    end
                    if (want.less_than !== got.less_than) begin
                        $error("less_than expected %0b actual %0b", want.less_than,
                               got.less_than);
                        errs++;
                    end
                    if (want.equal !== got.equal) begin
                        $error("equal expected %0b actual %0b", want.equal, got.equal);
                        errs++;
                    end
                    if (want.zero_den_error !== got.zero_den_error) begin
                        $error("zero_den_error expected %0b actual %0b", want.zero_den_error,
                               got.zero_den_error);
                        errs++;
                    end
                    if (want.overflow !== got.overflow) begin
                        $error("overflow expected %0b actual %0b", want.overflow,
                               got.overflow);
                        errs++;
                    end
                end
            end
        end
        o_pending = sums_due.size();
        if (errs != 0) begin
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

[tb/rational_add_reduce_compare_unit_tb.sv]
// Testbench top that drives requests into the rational unit and gives the verdict.
`timescale 1ns / 1ps
module rational_add_reduce_compare_unit_tb;
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rarc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [rarc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    int                               fail_count;
    int                               pending;
    logic                             calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rational_add_reduce_compare_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rational_add_reduce_compare_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
    end

    function automatic logic [31:0] pick_num();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(40)) - 20);
            3: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(6))
            0: return 31'd0;
            1: return 31'h7fff_ffff;
            2: return 31'($urandom_range(12) + 1);
            3: return 31'($urandom_range(1000) + 1);
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send_request(logic [31:0] ln, logic [30:0] ld, logic [31:0] rn,
                                logic [30:0] rd);
        s_axis_tdata <= {2'b00, rd, rn, ld, ln};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!calm && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [31:0] n;
        logic [30:0] d;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_request(32'd1, 31'd2, 32'd1, 31'd3);
        send_request(32'd1, 31'd2, 32'hffff_ffff, 31'd2);
        send_request(32'd3, 31'd0, 32'd1, 31'd2);
        send_request(32'd1, 31'd2, 32'd1, 31'd0);
        send_request(32'd0, 31'd0, 32'd0, 31'd0);
        send_request(32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
        send_request(32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        send_request(32'h8000_0000, 31'd1, 32'd0, 31'd1);
        send_request(32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
        send_request(32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_fffe);
        send_request(32'd2, 31'd4, 32'd1, 31'd2);
        send_request(32'd5, 31'd7, 32'd5, 31'd7);
        send_request(32'hffff_fffb, 31'd7, 32'd5, 31'd7);
        send_request(32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        send_request(32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        send_request(32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int i = 0; i < 500; i++) begin
            calm <= (i >= 200 && i < 260);
            n = pick_num();
            d = pick_den();
            if ($urandom_range(9) == 0) send_request(n, d, n, d);
            else send_request(n, d, pick_num(), pick_den());
        end
        s_axis_tvalid <= 1'b0;
        calm <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("rational_add_reduce_compare_unit_tb: clean");
        end else begin
            $display("rational_add_reduce_compare_unit_tb: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("rational_add_reduce_compare_unit_tb: errors");
        $finish;
    end
endmodule

[rational_add_reduce_compare_unit.f]
hdl/rarc_pkg.sv
hdl/rarc_front.sv
hdl/rarc_back.sv
hdl/rational_add_reduce_compare_unit.sv
hdl/rarc_checker.sv
tb/rational_add_reduce_compare_unit_checker.sv
tb/rational_add_reduce_compare_unit_tb.sv
